>>> hw/rtl/double_ended_priority_queue_assert.svh
// assertion macros shared by the priority queue rtl
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

// condition must never hold while out of reset
`define DEPQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("depq assertion failed");

// antecedent in one cycle implies consequent in the same cycle
`define DEPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("depq assertion failed");

// antecedent in one cycle implies consequent in the next cycle
`define DEPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("depq assertion failed");

`endif

>>> hw/rtl/depq_pkg.sv
// shared types and constants of the priority queue
`default_nettype none
package depq_pkg;

    localparam int ID_W  = 20;
    localparam int PRI_W = 24;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_POP_MAX = 2'd1;
    localparam logic [1:0] FUNC_POP_MIN = 2'd2;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic load_ins;
        logic shift_rem;
        logic find_max;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> hw/rtl/depq_cell.sv
// one storage cell of the queue with its slice of the comparison wave
`default_nettype none
module depq_cell
    import depq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int IDX      = 0,
    localparam int PW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [CW-1:0]    i_count,
    input  wire logic [PW-1:0]    i_pos,
    input  wire logic [ID_W-1:0]  i_ins_id,
    input  wire logic [PRI_W-1:0] i_ins_pri,
    input  wire logic [ID_W-1:0]  i_next_id,
    input  wire logic [PRI_W-1:0] i_next_pri,
    output logic      [ID_W-1:0]  o_id,
    output logic      [PRI_W-1:0] o_pri,
    input  wire logic             i_cand_vld,
    input  wire logic [PRI_W-1:0] i_cand_pri,
    input  wire logic [ID_W-1:0]  i_cand_id,
    input  wire logic [PW-1:0]    i_cand_pos,
    output logic                  o_cand_vld,
    output logic      [PRI_W-1:0] o_cand_pri,
    output logic      [ID_W-1:0]  o_cand_id,
    output logic      [PW-1:0]    o_cand_pos
);

    logic [ID_W-1:0]  r_id;
    logic [PRI_W-1:0] r_pri;
    logic             r_cand_vld;
    logic [PRI_W-1:0] r_cand_pri;
    logic [ID_W-1:0]  r_cand_id;
    logic [PW-1:0]    r_cand_pos;
    logic             active;
    logic             better;
    logic             take_own;

    assign active = CW'(IDX) < i_count;
    // max: ties go to this (newer) cell; min: ties keep the older candidate
    assign better = i_ctl.find_max ? (r_pri >= i_cand_pri) : (r_pri < i_cand_pri);
    assign take_own = active && (!i_cand_vld || better);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_ins && (CW'(IDX) == i_count)) begin
            r_id  <= i_ins_id;
            r_pri <= i_ins_pri;
        end else if (i_ctl.shift_rem && (PW'(IDX) >= i_pos)) begin
            r_id  <= i_next_id;
            r_pri <= i_next_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_vld <= 1'b0;
        end else begin
            r_cand_vld <= i_cand_vld || active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_own) begin
            r_cand_pri <= r_pri;
            r_cand_id  <= r_id;
            r_cand_pos <= PW'(IDX);
        end else begin
            r_cand_pri <= i_cand_pri;
            r_cand_id  <= i_cand_id;
            r_cand_pos <= i_cand_pos;
        end
    end

    assign o_id       = r_id;
    assign o_pri      = r_pri;
    assign o_cand_vld = r_cand_vld;
    assign o_cand_pri = r_cand_pri;
    assign o_cand_id  = r_cand_id;
    assign o_cand_pos = r_cand_pos;

endmodule
`default_nettype wire

>>> hw/rtl/double_ended_priority_queue.sv
// top level of the double-ended priority queue: sequencer and cell chain
`default_nettype none
// Bounded double-ended priority queue of (id, priority) words held in a
// row of CAPACITY cells, oldest entry in cell 0. A word is taken when start
// is high and busy is low; every word gives exactly one result, shown on the
// o_ ports for one cycle with o_valid high, and the receiver cannot stall it.
// An insert, an insert into a full queue, a pop of an empty queue or an
// unused code finishes at once: the result appears the cycle after the word
// is taken and busy never rises, so such words may follow every cycle.
// A pop of a non-empty queue holds busy through the scan and remove states
// and the result appears the cycle busy falls, so pops cannot overlap. The
// scan is the comparison wave, which walks the cell chain one cell per cycle
// to find the newest maximum or the oldest minimum; the remove state then
// takes the entry out, the cell holding it and every cell above it taking
// its upper neighbor's contents in parallel.
module double_ended_priority_queue
    import depq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       i_func,
    input  wire logic [ID_W-1:0]  i_client_id,
    input  wire logic [PRI_W-1:0] i_priority_req,
    output logic                  o_valid,
    output logic      [ID_W-1:0]  o_popped_id,
    output logic                  o_was_empty,
    output logic                  o_dropped_full
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REMOVE
    } t_state;

    // sequencer registers
    t_state           r_state,    n_state;
    logic [CW-1:0]    r_count,    n_count;
    logic [PW-1:0]    r_step,     n_step;
    logic             r_find_max, n_find_max;
    logic             r_valid,    n_valid;
    logic [ID_W-1:0]  r_popped,   n_popped;
    logic             r_empty,    n_empty;
    logic             r_full,     n_full;

    logic      accept;
    t_cell_ctl ctl;

    // chain wiring: stored words and the travelling candidate
    logic [ID_W-1:0]  cell_id  [CAPACITY+1];
    logic [PRI_W-1:0] cell_pri [CAPACITY+1];
    logic             cand_vld [CAPACITY+1];
    logic [PRI_W-1:0] cand_pri [CAPACITY+1];
    logic [ID_W-1:0]  cand_id  [CAPACITY+1];
    logic [PW-1:0]    cand_pos [CAPACITY+1];

    assign accept = start && !busy;

    // wave enters cell 0 empty and exits the top cell
    assign cand_vld[0] = 1'b0;
    assign cand_pri[0] = '0;
    assign cand_id[0]  = '0;
    assign cand_pos[0] = '0;
    // nothing above the top cell to shift down
    assign cell_id[CAPACITY]  = '0;
    assign cell_pri[CAPACITY] = '0;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_step     = r_step;
        n_find_max = r_find_max;
        n_valid    = 1'b0;
        n_popped   = r_popped;
        n_empty    = r_empty;
        n_full     = r_full;
        ctl.load_ins  = 1'b0;
        ctl.shift_rem = 1'b0;
        ctl.find_max  = r_find_max;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_valid  = 1'b1;
                    n_popped = '0;
                    n_empty  = 1'b0;
                    n_full   = 1'b0;
                    case (i_func) inside
                        FUNC_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_full = 1'b1;
                            end else begin
                                ctl.load_ins = 1'b1;
                                n_count      = r_count + CW'(1);
                            end
                        end
                        FUNC_POP_MAX, FUNC_POP_MIN: begin
                            if (r_count == '0) begin
                                n_empty = 1'b1;
                            end else begin
                                // result comes after the scan
                                n_valid    = 1'b0;
                                n_find_max = (i_func == FUNC_POP_MAX);
                                n_step     = '0;
                                n_state    = ST_SCAN;
                            end
                        end
                        default: begin
                            // unused code: plain all-zero result
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // wave has reached the top cell once the step hits the end
                n_step = r_step + PW'(1);
                if (r_step == PW'(CAPACITY - 1)) begin
                    n_state = ST_REMOVE;
                end
            end
            ST_REMOVE: begin
                ctl.shift_rem = 1'b1;
                n_valid  = 1'b1;
                n_popped = cand_id[CAPACITY];
                n_count  = r_count - CW'(1);
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_step     <= '0;
            r_find_max <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_step     <= n_step;
            r_find_max <= n_find_max;
            r_valid    <= n_valid;
        end
        r_popped <= n_popped;
        r_empty  <= n_empty;
        r_full   <= n_full;
    end

    // the cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        depq_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_count    (r_count),
            .i_pos      (cand_pos[CAPACITY]),
            .i_ins_id   (i_client_id),
            .i_ins_pri  (i_priority_req),
            .i_next_id  (cell_id[g+1]),
            .i_next_pri (cell_pri[g+1]),
            .o_id       (cell_id[g]),
            .o_pri      (cell_pri[g]),
            .i_cand_vld (cand_vld[g]),
            .i_cand_pri (cand_pri[g]),
            .i_cand_id  (cand_id[g]),
            .i_cand_pos (cand_pos[g]),
            .o_cand_vld (cand_vld[g+1]),
            .o_cand_pri (cand_pri[g+1]),
            .o_cand_id  (cand_id[g+1]),
            .o_cand_pos (cand_pos[g+1])
        );
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_popped_id    = r_popped;
    assign o_was_empty    = r_empty;
    assign o_dropped_full = r_full;

`include "double_ended_priority_queue_assert.svh"

    `DEPQ_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(CAPACITY))
    `DEPQ_ASSERT_NEVER(a_flags_excl, i_clk, i_rst_n, o_valid && o_was_empty && o_dropped_full)
    `DEPQ_ASSERT_IMPL(a_remove_has_cand, i_clk, i_rst_n, r_state == ST_REMOVE, cand_vld[CAPACITY] && (r_count != '0))
    `DEPQ_ASSERT_NEXT(a_remove_shrinks, i_clk, i_rst_n, r_state == ST_REMOVE, o_valid && (r_count == $past(r_count) - CW'(1)))
    `DEPQ_ASSERT_NEXT(a_busy_no_result, i_clk, i_rst_n, r_state == ST_SCAN, !o_valid)

endmodule
`default_nettype wire
